>>> rtl/core/rgb_block_to_ycbcr420_unit_defines.svh
// assertion macros used by the checker file of the color conversion block
`ifndef RGB_BLOCK_TO_YCBCR420_UNIT_DEFINES_SVH
`define RGB_BLOCK_TO_YCBCR420_UNIT_DEFINES_SVH

// expression must hold at every edge out of reset
`define RBYC_ASSERT_HOLD(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rgb_block_to_ycbcr420_unit: invariant violated");

// consequent must follow whenever the antecedent holds
`define RBYC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("rgb_block_to_ycbcr420_unit: implication violated");

`endif

>>> rtl/core/rbyc_pkg.sv
// shared types and fixed-point coefficients for the rgb to ycbcr 4:2:0 block
`default_nettype none

package rbyc_pkg;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = PIX_W + COEF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FRAC_W  = 16;
    localparam int NUM_PIX = 4;
    localparam int CSUM_W  = PIX_W + 2;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } ycc_t;

    // coefficient magnitudes, scaled by 2^16; signs are applied in the adders
    localparam logic [COEF_W-1:0] Y_R  = 16'd16843;
    localparam logic [COEF_W-1:0] Y_G  = 16'd33030;
    localparam logic [COEF_W-1:0] Y_B  = 16'd6423;
    localparam logic [COEF_W-1:0] CB_R = 16'd9699;
    localparam logic [COEF_W-1:0] CB_G = 16'd19071;
    localparam logic [COEF_W-1:0] CB_B = 16'd28770;
    localparam logic [COEF_W-1:0] CR_R = 16'd28770;
    localparam logic [COEF_W-1:0] CR_G = 16'd24117;
    localparam logic [COEF_W-1:0] CR_B = 16'd4653;

    localparam logic [PIX_W-1:0] Y_OFFSET = 8'd16;
    // 128 << 16: folds the chroma offset into a bias that keeps the sum positive
    localparam logic [SUM_W-1:0] C_BIAS   = 25'd8388608;

endpackage

`default_nettype wire

>>> rtl/core/rbyc_pixel_conv.sv
// per-pixel conversion: registered products, then registered sums and scaling
`default_nettype none

module rbyc_pixel_conv (
    input  wire logic          clk,
    input  wire rbyc_pkg::rgb_t pix,
    output rbyc_pkg::ycc_t     ycc
);
    import rbyc_pkg::*;

    typedef struct packed {
        logic [PROD_W-1:0] yr;
        logic [PROD_W-1:0] yg;
        logic [PROD_W-1:0] yb;
        logic [PROD_W-1:0] br;
        logic [PROD_W-1:0] bg;
        logic [PROD_W-1:0] bb;
        logic [PROD_W-1:0] rr;
        logic [PROD_W-1:0] rg;
        logic [PROD_W-1:0] rb;
    } prod_t;

    prod_t             prod_reg;
    prod_t             prod_next;
    ycc_t              ycc_reg;
    ycc_t              ycc_next;
    logic [SUM_W-1:0]  y_sum;
    logic [SUM_W-1:0]  cb_sum;
    logic [SUM_W-1:0]  cr_sum;

    always_comb
    begin
        prod_next.yr = PROD_W'(pix.red)   * PROD_W'(Y_R);
        prod_next.yg = PROD_W'(pix.green) * PROD_W'(Y_G);
        prod_next.yb = PROD_W'(pix.blue)  * PROD_W'(Y_B);
        prod_next.br = PROD_W'(pix.red)   * PROD_W'(CB_R);
        prod_next.bg = PROD_W'(pix.green) * PROD_W'(CB_G);
        prod_next.bb = PROD_W'(pix.blue)  * PROD_W'(CB_B);
        prod_next.rr = PROD_W'(pix.red)   * PROD_W'(CR_R);
        prod_next.rg = PROD_W'(pix.green) * PROD_W'(CR_G);
        prod_next.rb = PROD_W'(pix.blue)  * PROD_W'(CR_B);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // sums stay within 0 .. 2^24-1 after biasing, so modular math is exact
    always_comb
    begin
        y_sum  = SUM_W'(prod_reg.yr) + SUM_W'(prod_reg.yg) + SUM_W'(prod_reg.yb);
        cb_sum = C_BIAS + SUM_W'(prod_reg.bb) - SUM_W'(prod_reg.br)
                 - SUM_W'(prod_reg.bg);
        cr_sum = C_BIAS + SUM_W'(prod_reg.rr) - SUM_W'(prod_reg.rg)
                 - SUM_W'(prod_reg.rb);
        ycc_next.luma = y_sum[FRAC_W+PIX_W-1:FRAC_W] + Y_OFFSET;
        ycc_next.cb   = cb_sum[FRAC_W+PIX_W-1:FRAC_W];
        ycc_next.cr   = cr_sum[FRAC_W+PIX_W-1:FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        ycc_reg <= ycc_next;
    end

    assign ycc = ycc_reg;

endmodule

`default_nettype wire

>>> rtl/core/rbyc_chroma_avg.sv
// averages the four per-pixel chroma values and registers the block result
`default_nettype none

module rbyc_chroma_avg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire rbyc_pkg::ycc_t ycc [rbyc_pkg::NUM_PIX],
    output logic                out_valid,
    output logic [7:0]          luma [rbyc_pkg::NUM_PIX],
    output logic [7:0]          cb,
    output logic [7:0]          cr
);
    import rbyc_pkg::*;

    logic                 valid_reg;
    logic [PIX_W-1:0]     luma_reg [NUM_PIX];
    logic [PIX_W-1:0]     cb_reg;
    logic [PIX_W-1:0]     cr_reg;
    logic [CSUM_W-1:0]    cb_sum;
    logic [CSUM_W-1:0]    cr_sum;

    always_comb
    begin
        cb_sum = '0;
        cr_sum = '0;
        for (int i = 0; i < NUM_PIX; i++)
        begin
            cb_sum = cb_sum + CSUM_W'(ycc[i].cb);
            cr_sum = cr_sum + CSUM_W'(ycc[i].cr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_PIX; i++)
        begin
            luma_reg[i] <= ycc[i].luma;
        end
        cb_reg <= cb_sum[CSUM_W-1:2];
        cr_reg <= cr_sum[CSUM_W-1:2];
    end

    assign out_valid = valid_reg;
    assign luma      = luma_reg;
    assign cb        = cb_reg;
    assign cr        = cr_reg;

endmodule

`default_nettype wire

>>> rtl/core/rgb_block_to_ycbcr420_unit.sv
// top level: 2x2 rgb block to bt.601 studio-range luma plus 4:2:0 chroma
//
// One 2x2 block is taken on every clock (busy stays low) and its result shows up
// on done after one register stage for the constant-coefficient products, one
// for the per-pixel sums and scaling, and one for the chroma average and output
// register. Results stand for exactly one cycle while done is high; the
// receiver cannot stall them, so it must take each one when it appears. Reset
// clears only the valid pipeline.
`default_nettype none

module rgb_block_to_ycbcr420_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    output logic            done,
    input  wire logic [7:0] tl_red,
    input  wire logic [7:0] tl_green,
    input  wire logic [7:0] tl_blue,
    input  wire logic [7:0] tr_red,
    input  wire logic [7:0] tr_green,
    input  wire logic [7:0] tr_blue,
    input  wire logic [7:0] bl_red,
    input  wire logic [7:0] bl_green,
    input  wire logic [7:0] bl_blue,
    input  wire logic [7:0] br_red,
    input  wire logic [7:0] br_green,
    input  wire logic [7:0] br_blue,
    output logic [7:0]      luma_tl,
    output logic [7:0]      luma_tr,
    output logic [7:0]      luma_bl,
    output logic [7:0]      luma_br,
    output logic [7:0]      chroma_blue,
    output logic [7:0]      chroma_red
);
    import rbyc_pkg::*;

    rgb_t              pix [NUM_PIX];
    ycc_t              ycc [NUM_PIX];
    logic [PIX_W-1:0]  luma [NUM_PIX];
    logic              accept;
    logic              valid1_reg;
    logic              valid2_reg;

    // the pipeline never stalls, so every request is taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pix[0] = '{red: tl_red, green: tl_green, blue: tl_blue};
    assign pix[1] = '{red: tr_red, green: tr_green, blue: tr_blue};
    assign pix[2] = '{red: bl_red, green: bl_green, blue: bl_blue};
    assign pix[3] = '{red: br_red, green: br_green, blue: br_blue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= accept;
            valid2_reg <= valid1_reg;
        end
    end

    for (genvar i = 0; i < NUM_PIX; i++)
    begin : g_pix
        rbyc_pixel_conv u_conv (
            .clk (clk),
            .pix (pix[i]),
            .ycc (ycc[i])
        );
    end

    rbyc_chroma_avg u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid2_reg),
        .ycc       (ycc),
        .out_valid (done),
        .luma      (luma),
        .cb        (chroma_blue),
        .cr        (chroma_red)
    );

    assign luma_tl = luma[0];
    assign luma_tr = luma[1];
    assign luma_bl = luma[2];
    assign luma_br = luma[3];

endmodule

`default_nettype wire

>>> rtl/core/rbyc_checker.sv
// port-level checker for the color conversion block and its bind
`default_nettype none

`include "rgb_block_to_ycbcr420_unit_defines.svh"

module rbyc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [7:0] luma_tl,
    input wire logic [7:0] luma_tr,
    input wire logic [7:0] luma_bl,
    input wire logic [7:0] luma_br,
    input wire logic [7:0] chroma_blue,
    input wire logic [7:0] chroma_red
);

    logic luma_ok;
    logic chroma_ok;

    // studio range bounds of the result fields
    assign luma_ok = (luma_tl >= 8'd16) && (luma_tl <= 8'd235)
                     && (luma_tr >= 8'd16) && (luma_tr <= 8'd235)
                     && (luma_bl >= 8'd16) && (luma_bl <= 8'd235)
                     && (luma_br >= 8'd16) && (luma_br <= 8'd235);
    assign chroma_ok = (chroma_blue >= 8'd16) && (chroma_blue <= 8'd240)
                       && (chroma_red >= 8'd16) && (chroma_red <= 8'd240);

    `RBYC_ASSERT_HOLD(a_never_busy, !busy)
    `RBYC_ASSERT_IMPL(a_request_gives_result, start && !busy, ##3 done)
    `RBYC_ASSERT_IMPL(a_result_has_request, done, $past(start && !busy, 3))
    `RBYC_ASSERT_IMPL(a_result_range, done, (luma_ok && chroma_ok))

endmodule

bind rgb_block_to_ycbcr420_unit rbyc_checker u_rbyc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .luma_tl     (luma_tl),
    .luma_tr     (luma_tr),
    .luma_bl     (luma_bl),
    .luma_br     (luma_br),
    .chroma_blue (chroma_blue),
    .chroma_red  (chroma_red)
);

`default_nettype wire

>>> test/tb_rgb_block_to_ycbcr420_unit.sv
// testbench for the 2x2 rgb block to ycbcr 4:2:0 converter
module tb_rgb_block_to_ycbcr420_unit;
    import rbyc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int GAP_PCT      = 13;

    // pixel order inside a block: 0 tl, 1 tr, 2 bl, 3 br
    typedef rgb_t [NUM_PIX-1:0] rgb_quad_t;

    typedef struct packed {
        logic [PIX_W-1:0] luma_tl;
        logic [PIX_W-1:0] luma_tr;
        logic [PIX_W-1:0] luma_bl;
        logic [PIX_W-1:0] luma_br;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
    } block_ycc_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       start    = 1'b0;
    logic [7:0] tl_red   = '0;
    logic [7:0] tl_green = '0;
    logic [7:0] tl_blue  = '0;
    logic [7:0] tr_red   = '0;
    logic [7:0] tr_green = '0;
    logic [7:0] tr_blue  = '0;
    logic [7:0] bl_red   = '0;
    logic [7:0] bl_green = '0;
    logic [7:0] bl_blue  = '0;
    logic [7:0] br_red   = '0;
    logic [7:0] br_green = '0;
    logic [7:0] br_blue  = '0;
    logic       busy;
    logic       done;
    logic [7:0] luma_tl;
    logic [7:0] luma_tr;
    logic [7:0] luma_bl;
    logic [7:0] luma_br;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;

    block_ycc_t pending_blocks[$];
    block_ycc_t want;
    int         error_count    = 0;
    int         blocks_sent    = 0;
    int         blocks_checked = 0;
    int         cycle_count    = 0;
    bit         gaps_enabled   = 1'b1;

    rgb_block_to_ycbcr420_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .done        (done),
        .tl_red      (tl_red),
        .tl_green    (tl_green),
        .tl_blue     (tl_blue),
        .tr_red      (tr_red),
        .tr_green    (tr_green),
        .tr_blue     (tr_blue),
        .bl_red      (bl_red),
        .bl_green    (bl_green),
        .bl_blue     (bl_blue),
        .br_red      (br_red),
        .br_green    (br_green),
        .br_blue     (br_blue),
        .luma_tl     (luma_tl),
        .luma_tr     (luma_tr),
        .luma_bl     (luma_bl),
        .luma_br     (luma_br),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // offset plus floor of the 2^16-scaled sum
    function automatic int descale(int acc, int offset);
        return offset + (acc >>> FRAC_W);
    endfunction

    function automatic block_ycc_t convert_block(rgb_quad_t px);
        block_ycc_t       res;
        logic [PIX_W-1:0] luma [NUM_PIX];
        int               r;
        int               g;
        int               b;
        int               cb_total;
        int               cr_total;
        cb_total = 0;
        cr_total = 0;
        for (int p = 0; p < NUM_PIX; p++)
        begin
            r = px[p].red;
            g = px[p].green;
            b = px[p].blue;
            luma[p]   = 8'(descale(16843 * r + 33030 * g + 6423 * b, 16));
            cb_total += descale(-9699 * r - 19071 * g + 28770 * b, 128);
            cr_total += descale(28770 * r - 24117 * g - 4653 * b, 128);
        end
        res.luma_tl = luma[0];
        res.luma_tr = luma[1];
        res.luma_bl = luma[2];
        res.luma_br = luma[3];
        res.cb      = 8'(cb_total >> 2);
        res.cr      = 8'(cr_total >> 2);
        return res;
    endfunction

    function automatic rgb_t make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        rgb_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // extreme_pct percent of channels land on 0 or 255
    function automatic logic [7:0] random_level(int extreme_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < extreme_pct / 2)
            return 8'h00;
        if (roll < extreme_pct)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic rgb_quad_t random_block(int extreme_pct);
        rgb_quad_t  px;
        logic [7:0] level;
        for (int p = 0; p < NUM_PIX; p++)
        begin
            // gray pixels put the chroma sums right at zero
            if ($urandom_range(9) == 0)
            begin
                level = random_level(extreme_pct);
                px[p] = make_pixel(level, level, level);
            end
            else
                px[p] = make_pixel(random_level(extreme_pct), random_level(extreme_pct),
                                   random_level(extreme_pct));
        end
        return px;
    endfunction

    // called at a clock edge, returns at the edge that accepted the request
    task automatic send_block(input rgb_quad_t px);
        while (gaps_enabled && $urandom_range(99) < GAP_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        tl_red   <= px[0].red;
        tl_green <= px[0].green;
        tl_blue  <= px[0].blue;
        tr_red   <= px[1].red;
        tr_green <= px[1].green;
        tr_blue  <= px[1].blue;
        bl_red   <= px[2].red;
        bl_green <= px[2].green;
        bl_blue  <= px[2].blue;
        br_red   <= px[3].red;
        br_green <= px[3].green;
        br_blue  <= px[3].blue;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_blocks.push_back(convert_block(px));
        blocks_sent++;
    endtask

    task automatic send_uniform(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        rgb_t px;
        px = make_pixel(r, g, b);
        send_block({px, px, px, px});
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    task automatic test_directed();
        send_uniform(8'h00, 8'h00, 8'h00);
        send_uniform(8'hFF, 8'hFF, 8'hFF);
        send_uniform(8'hFF, 8'h00, 8'h00);
        send_uniform(8'h00, 8'hFF, 8'h00);
        send_uniform(8'h00, 8'h00, 8'hFF);
        // lowest cb and lowest cr
        send_uniform(8'hFF, 8'hFF, 8'h00);
        send_uniform(8'h00, 8'hFF, 8'hFF);
        send_uniform(8'hFF, 8'h00, 8'hFF);
        // tiny negative sums must round toward minus infinity
        send_uniform(8'h01, 8'h00, 8'h00);
        send_uniform(8'h00, 8'h01, 8'h00);
        send_uniform(8'h00, 8'h00, 8'h01);
        send_uniform(8'h80, 8'h80, 8'h80);
        send_block({make_pixel(8'h00, 8'h00, 8'hFF), make_pixel(8'hFF, 8'h00, 8'h00),
                    make_pixel(8'h00, 8'h00, 8'h00), make_pixel(8'hFF, 8'hFF, 8'hFF)});
        send_block({make_pixel(8'hFF, 8'hFF, 8'hFF), make_pixel(8'h00, 8'h00, 8'h00),
                    make_pixel(8'hFF, 8'h00, 8'h00), make_pixel(8'h00, 8'h00, 8'hFF)});
        send_block({make_pixel(8'hFF, 8'h00, 8'hFF), make_pixel(8'h00, 8'hFF, 8'hFF),
                    make_pixel(8'hFF, 8'hFF, 8'h00), make_pixel(8'h00, 8'hFF, 8'h00)});
        send_block({make_pixel(8'h55, 8'hAA, 8'h55), make_pixel(8'hAA, 8'h55, 8'hAA),
                    make_pixel(8'hAA, 8'h55, 8'hAA), make_pixel(8'h55, 8'hAA, 8'h55)});
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 500; i++)
            send_block(random_block(20));
    endtask

    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        for (int i = 0; i < 350; i++)
            send_block(random_block(20));
        gaps_enabled = 1'b1;
    endtask

    task automatic test_bursts_with_drain();
        for (int burst = 0; burst < 15; burst++)
        begin
            for (int i = 0; i < 20; i++)
                send_block(random_block(30));
            drain_results();
        end
    endtask

    task automatic test_extreme_mix();
        for (int i = 0; i < 100; i++)
            send_block(random_block(80));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("result strobe with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                check_field("luma_tl", want.luma_tl, luma_tl);
                check_field("luma_tr", want.luma_tr, luma_tr);
                check_field("luma_bl", want.luma_bl, luma_bl);
                check_field("luma_br", want.luma_br, luma_br);
                check_field("chroma_blue", want.cb, chroma_blue);
                check_field("chroma_red", want.cr, chroma_red);
                blocks_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_blocks.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_back_to_back();
        test_bursts_with_drain();
        test_extreme_mix();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_blocks.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_blocks.size());
            error_count++;
        end
        $display("sent %0d rgb blocks, checked %0d ycbcr results, %0d mismatches",
                 blocks_sent, blocks_checked, error_count);
        $display("covered channel extremes, primaries, rounding of small negatives, "
                 , "back-to-back requests, random gaps and full drains");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rbyc_pkg.sv
rtl/core/rbyc_pixel_conv.sv
rtl/core/rbyc_chroma_avg.sv
rtl/core/rgb_block_to_ycbcr420_unit.sv
rtl/core/rbyc_checker.sv
test/tb_rgb_block_to_ycbcr420_unit.sv
